>>> design/fzap_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fzap_pkg
// Shared types, constants and helpers of the forbidden-zone path selector.
// ============================================================================
package fzap_pkg;

    // Angles are in centidegrees.
    localparam int FULL_TURN       = 36000;
    localparam int HALF_TURN       = 18000;
    localparam int WAYPOINT_STEP   = 500;
    localparam int ARRIVE_MARGIN   = 250;
    localparam int WAYPOINT_LIMIT_DEF = 72;

    localparam int ANGLE_W = 17;  // signed angle on the ports
    localparam int WRAP_W  = 16;  // wrapped angle, 0 to 35999
    localparam int REG_W   = 16;  // configuration register width
    localparam int IDX_W   = 1;   // configuration register index width

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_ZONE_LOW  = 1'b0;
    localparam logic [IDX_W-1:0] REG_ZONE_HIGH = 1'b1;

    // Walk direction codes.
    localparam logic DIR_CW  = 1'b0;
    localparam logic DIR_CCW = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_DELTA,
        ST_WALK,
        ST_DONE
    } t_state;

    // Forbidden zone edges.
    typedef struct packed {
        logic [REG_W-1:0] lo;
        logic [REG_W-1:0] hi;
    } t_zone;

    // What the step unit reports for the current waypoint.
    typedef struct packed {
        logic              blocked;
        logic              arrive;
        logic [WRAP_W-1:0] next;
    } t_step_res;

    // Reduce any 17-bit signed angle into 0..35999.
    function automatic logic [WRAP_W-1:0] wrap_full(input logic signed [ANGLE_W-1:0] v);
        logic signed [18:0] sx;
        logic [17:0]        ux;
        logic [17:0]        r;
        begin
            sx = 19'(v) + 19'sd72000;
            ux = sx[17:0];
            if (ux >= 18'd108000) begin
                r = ux - 18'd108000;
            end else if (ux >= 18'd72000) begin
                r = ux - 18'd72000;
            end else if (ux >= 18'(FULL_TURN)) begin
                r = ux - 18'(FULL_TURN);
            end else begin
                r = ux;
            end
            wrap_full = r[WRAP_W-1:0];
        end
    endfunction

endpackage

>>> design/fzap_step_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// fzap_step_unit
// Shared waypoint unit: zone test, one 5-degree advance and arrival check.
// ============================================================================
module fzap_step_unit (
    input  fzap_pkg::t_zone            i_zone,
    input  logic [fzap_pkg::WRAP_W-1:0] i_way,
    input  logic [fzap_pkg::WRAP_W-1:0] i_tgt,
    input  logic                        i_dir,
    output fzap_pkg::t_step_res         o_res
);
    import fzap_pkg::*;

    logic               in_zone;
    logic signed [16:0] step;
    logic signed [16:0] sum;
    logic signed [16:0] nxt;
    logic signed [16:0] diff;

    // Zone test on the present waypoint; equal edges mean no zone.
    always_comb begin
        if (i_zone.lo == i_zone.hi) begin
            in_zone = 1'b0;
        end else if (i_zone.lo < i_zone.hi) begin
            in_zone = (i_way >= i_zone.lo) && (i_way <= i_zone.hi);
        end else begin
            in_zone = (i_way >= i_zone.lo) || (i_way <= i_zone.hi);
        end
    end

    // Advance one waypoint in the chosen direction and fold back into the circle.
    always_comb begin
        step = (i_dir == DIR_CCW) ? -17'sd500 : 17'sd500;
        sum  = signed'({1'b0, i_way}) + step;
        if (sum < 17'sd0) begin
            nxt = sum + 17'(FULL_TURN);
        end else if (sum >= 17'(FULL_TURN)) begin
            nxt = sum - 17'(FULL_TURN);
        end else begin
            nxt = sum;
        end
    end

    // Arrival: circular distance from the new waypoint to the target below the margin.
    always_comb begin
        diff = nxt - signed'({1'b0, i_tgt});
        o_res.arrive  = ((diff > -17'sd250) && (diff < 17'sd250))
                     || (diff > 17'sd35750) || (diff < -17'sd35750);
        o_res.blocked = in_zone;
        o_res.next    = nxt[WRAP_W-1:0];
    end

endmodule

>>> design/fzap_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// fzap_ctrl
// Sequencer: wraps the angles, runs both walks through the step unit and
// picks the move.
// ============================================================================
module fzap_ctrl #(
    parameter int WAYPOINT_LIMIT = fzap_pkg::WAYPOINT_LIMIT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [fzap_pkg::ANGLE_W-1:0] i_current_angle,
    input  logic signed [fzap_pkg::ANGLE_W-1:0] i_target_angle,
    output logic [fzap_pkg::WRAP_W-1:0]         o_way,
    output logic [fzap_pkg::WRAP_W-1:0]         o_tgt,
    output logic                                o_dir,
    input  fzap_pkg::t_step_res                 i_res,
    output logic                                o_done,
    output logic signed [fzap_pkg::ANGLE_W-1:0] o_move_delta,
    output logic                                o_both_blocked
);
    import fzap_pkg::*;

    localparam int CNT_W = $clog2(WAYPOINT_LIMIT + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WAYPOINT_LIMIT - 1);

    t_state                     r_state, n_state;
    logic                       r_done, n_done;
    logic signed [ANGLE_W-1:0]  r_raw_cur, n_raw_cur;
    logic signed [ANGLE_W-1:0]  r_raw_tgt, n_raw_tgt;
    logic [WRAP_W-1:0]          r_cur, n_cur;
    logic [WRAP_W-1:0]          r_tgt, n_tgt;
    logic [WRAP_W-1:0]          r_dcw, n_dcw;
    logic [WRAP_W-1:0]          r_way, n_way;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic                       r_dir, n_dir;
    logic                       r_cw_blk, n_cw_blk;
    logic                       r_ccw_blk, n_ccw_blk;
    logic signed [ANGLE_W-1:0]  r_delta, n_delta;
    logic                       r_both, n_both;

    logic signed [ANGLE_W-1:0]  diff;
    logic [WRAP_W-1:0]          dccw;
    logic                       walk_end;
    logic signed [ANGLE_W-1:0]  pos_delta;
    logic signed [ANGLE_W-1:0]  neg_delta;

    // Next state and datapath updates.
    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_raw_cur = r_raw_cur;
        n_raw_tgt = r_raw_tgt;
        n_cur     = r_cur;
        n_tgt     = r_tgt;
        n_dcw     = r_dcw;
        n_way     = r_way;
        n_cnt     = r_cnt;
        n_dir     = r_dir;
        n_cw_blk  = r_cw_blk;
        n_ccw_blk = r_ccw_blk;
        n_delta   = r_delta;
        n_both    = r_both;

        diff      = signed'({1'b0, r_tgt}) - signed'({1'b0, r_cur});
        dccw      = (r_dcw == '0) ? '0 : WRAP_W'(FULL_TURN) - r_dcw;
        walk_end  = i_res.blocked || i_res.arrive || (r_cnt == CNT_LAST);
        pos_delta = signed'({1'b0, r_dcw});
        neg_delta = -signed'({1'b0, dccw});

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_raw_cur = i_current_angle;
                    n_raw_tgt = i_target_angle;
                    n_state   = ST_WRAP;
                end
            end
            ST_WRAP: begin
                n_cur   = wrap_full(r_raw_cur);
                n_tgt   = wrap_full(r_raw_tgt);
                n_state = ST_DELTA;
            end
            ST_DELTA: begin
                // Clockwise distance, then set up the clockwise walk.
                n_dcw     = (diff < 0) ? WRAP_W'(diff + 17'(FULL_TURN)) : WRAP_W'(diff);
                n_way     = r_cur;
                n_cnt     = '0;
                n_dir     = DIR_CW;
                n_cw_blk  = 1'b0;
                n_ccw_blk = 1'b0;
                n_state   = ST_WALK;
            end
            ST_WALK: begin
                if (walk_end) begin
                    if (r_dir == DIR_CW) begin
                        n_cw_blk = i_res.blocked;
                        n_dir    = DIR_CCW;
                        n_way    = r_cur;
                        n_cnt    = '0;
                    end else begin
                        n_ccw_blk = i_res.blocked;
                        n_state   = ST_DONE;
                    end
                end else begin
                    n_way = i_res.next;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                // Take the free path; otherwise the shorter one, clockwise on a tie.
                if (r_cw_blk && !r_ccw_blk) begin
                    n_delta = neg_delta;
                end else if (!r_cw_blk && r_ccw_blk) begin
                    n_delta = pos_delta;
                end else begin
                    n_delta = (r_dcw <= WRAP_W'(HALF_TURN)) ? pos_delta : neg_delta;
                end
                n_both  = r_cw_blk && r_ccw_blk;
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_raw_cur <= n_raw_cur;
        r_raw_tgt <= n_raw_tgt;
        r_cur     <= n_cur;
        r_tgt     <= n_tgt;
        r_dcw     <= n_dcw;
        r_way     <= n_way;
        r_cnt     <= n_cnt;
        r_dir     <= n_dir;
        r_cw_blk  <= n_cw_blk;
        r_ccw_blk <= n_ccw_blk;
        r_delta   <= n_delta;
        r_both    <= n_both;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_way          = r_way;
    assign o_tgt          = r_tgt;
    assign o_dir          = r_dir;
    assign o_done         = r_done;
    assign o_move_delta   = r_delta;
    assign o_both_blocked = r_both;

    // A result strobe follows the select state only.
    a_done_after_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_DONE))
        else $error("result strobe without a select cycle");

    // The waypoint counter never passes the walk limit.
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_cnt <= CNT_LAST))
        else $error("waypoint counter beyond limit");

    // Waypoints stay on the circle.
    a_way_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_way < WRAP_W'(FULL_TURN)))
        else $error("waypoint outside 0..35999");

    // The both-blocked flag agrees with the two walk outcomes.
    a_both_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_both_blocked == (r_cw_blk && r_ccw_blk)))
        else $error("both-blocked flag mismatch");

endmodule

>>> design/forbidden_zone_angular_path_select.sv
`timescale 1ns / 1ps
// ============================================================================
// forbidden_zone_angular_path_select
// Chooses a clockwise or counter-clockwise joint move that avoids a
// configurable forbidden zone.
// ============================================================================
// Usage:
//   A request is taken at a rising edge with start high and busy low; the
//   current and target angles (centidegrees) are sampled there. busy then
//   stays high until the result is selected.
//   The result (o_move_delta, o_both_blocked) is shown for exactly one cycle
//   with o_done high. The receiver cannot stall it and must take it then.
//   From acceptance the sequencer wraps the angles, takes the clockwise distance,
//   walks each way (1 to WAYPOINT_LIMIT waypoints, one waypoint per cycle through
//   the shared step unit) and then selects the move.
//   The next request may be taken in the cycle the strobe is shown.
//   Configuration: write zone_low (index 0) or zone_high (index 1) with
//   i_cfg_we while the block is idle. Equal edges disable the zone.
//   Reset clears both zone registers (no zone) and returns the sequencer to
//   idle; no result is pending after reset.
// ============================================================================
module forbidden_zone_angular_path_select #(
    parameter int WAYPOINT_LIMIT = fzap_pkg::WAYPOINT_LIMIT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [fzap_pkg::ANGLE_W-1:0] i_current_angle,
    input  logic signed [fzap_pkg::ANGLE_W-1:0] i_target_angle,
    input  logic                                i_cfg_we,
    input  logic [fzap_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [fzap_pkg::REG_W-1:0]          i_cfg_data,
    output logic                                o_done,
    output logic signed [fzap_pkg::ANGLE_W-1:0] o_move_delta,
    output logic                                o_both_blocked
);
    import fzap_pkg::*;

    t_zone             r_zone, n_zone;
    t_step_res         step_res;
    logic [WRAP_W-1:0] way;
    logic [WRAP_W-1:0] tgt;
    logic              dir;

    // Configuration register decode.
    always_comb begin
        n_zone = r_zone;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ZONE_LOW:  n_zone.lo = i_cfg_data;
                REG_ZONE_HIGH: n_zone.hi = i_cfg_data;
                default:       n_zone    = r_zone;
            endcase
        end
    end

    // Zone registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else begin
            r_zone <= n_zone;
        end
    end

    // Sequencer.
    fzap_ctrl #(
        .WAYPOINT_LIMIT (WAYPOINT_LIMIT)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_current_angle (i_current_angle),
        .i_target_angle  (i_target_angle),
        .o_way           (way),
        .o_tgt           (tgt),
        .o_dir           (dir),
        .i_res           (step_res),
        .o_done          (o_done),
        .o_move_delta    (o_move_delta),
        .o_both_blocked  (o_both_blocked)
    );

    // Shared waypoint unit.
    fzap_step_unit u_step (
        .i_zone (r_zone),
        .i_way  (way),
        .i_tgt  (tgt),
        .i_dir  (dir),
        .o_res  (step_res)
    );

endmodule

>>> tb/fzap_move_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// fzap_move_checker
// Watches the request, configuration and result ports of the forbidden-zone
// path selector, predicts every move from its own copy of the zone registers
// and compares each result strobe, field by field, with the oldest prediction.
// ============================================================================
module fzap_move_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic signed [fzap_pkg::ANGLE_W-1:0] i_current_angle,
    input  logic signed [fzap_pkg::ANGLE_W-1:0] i_target_angle,
    input  logic                                i_cfg_we,
    input  logic [fzap_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [fzap_pkg::REG_W-1:0]          i_cfg_data,
    input  logic                                i_done,
    input  logic signed [fzap_pkg::ANGLE_W-1:0] i_move_delta,
    input  logic                                i_both_blocked,
    output int                                  o_fail_count,
    output logic                                o_drained
);
    import fzap_pkg::*;

    typedef struct {
        logic signed [ANGLE_W-1:0] delta;
        logic                      both_blocked;
    } t_move;

    t_move            planned_moves[$];
    logic [REG_W-1:0] zone_lo_q;
    logic [REG_W-1:0] zone_hi_q;
    int               fails = 0;

    assign o_fail_count = fails;

    // Any 17-bit angle folded onto the circle, 0 to 35999.
    function automatic int to_circle(input logic signed [ANGLE_W-1:0] a);
        int r;
        r = int'(a) % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        return r;
    endfunction

    // Zone edges are inclusive; equal edges mean no zone, a low edge above
    // the high edge means the zone runs through zero.
    function automatic bit zone_holds(input int a, input logic [REG_W-1:0] lo,
                                      input logic [REG_W-1:0] hi);
        int l;
        int h;
        l = int'(lo);
        h = int'(hi);
        if (l == h) return 1'b0;
        if (l < h) return (a >= l) && (a <= h);
        return (a >= l) || (a <= h);
    endfunction

    // Steps round the circle from the start, testing each waypoint before
    // moving on, until one comes within the arrival margin of the target or the waypoint limit is reached.
    function automatic bit walk_blocked(input int from, input int to, input logic dir,
                                        input logic [REG_W-1:0] lo,
                                        input logic [REG_W-1:0] hi);
        int pos;
        int d;
        pos = from;
        for (int i = 0; i < WAYPOINT_LIMIT_DEF; i++) begin
            if (zone_holds(pos, lo, hi)) return 1'b1;
            if (dir == DIR_CCW) begin
                pos = (pos - WAYPOINT_STEP + FULL_TURN) % FULL_TURN;
            end else begin
                pos = (pos + WAYPOINT_STEP) % FULL_TURN;
            end
            d = pos - to;
            while (d > HALF_TURN) d -= FULL_TURN;
            while (d <= -HALF_TURN) d += FULL_TURN;
            if (d < 0) d = -d;
            if (d < ARRIVE_MARGIN) break;
        end
        return 1'b0;
    endfunction

    // The move the block should choose for one request.
    function automatic t_move predict_move(input logic signed [ANGLE_W-1:0] cur_raw,
                                           input logic signed [ANGLE_W-1:0] tgt_raw,
                                           input logic [REG_W-1:0] lo,
                                           input logic [REG_W-1:0] hi);
        int    cur;
        int    tgt;
        int    dcw;
        int    dccw;
        int    delta;
        bit    cw_blk;
        bit    ccw_blk;
        t_move m;
        cur     = to_circle(cur_raw);
        tgt     = to_circle(tgt_raw);
        dcw     = (tgt - cur + FULL_TURN) % FULL_TURN;
        dccw    = (cur - tgt + FULL_TURN) % FULL_TURN;
        cw_blk  = walk_blocked(cur, tgt, DIR_CW, lo, hi);
        ccw_blk = walk_blocked(cur, tgt, DIR_CCW, lo, hi);
        if (cw_blk && !ccw_blk) begin
            delta = -dccw;
        end else if (!cw_blk && ccw_blk) begin
            delta = dcw;
        end else begin
            // Shorter way round; clockwise wins a tie.
            delta = (dcw <= dccw) ? dcw : -dccw;
        end
        m.delta        = delta[ANGLE_W-1:0];
        m.both_blocked = cw_blk && ccw_blk;
        return m;
    endfunction

    // Results are retired before new requests are logged, so a request taken
    // in the strobe cycle queues behind the one being answered.
    always @(posedge i_clk) begin
        t_move want;
        if (!i_rst_n) begin
            zone_lo_q <= '0;
            zone_hi_q <= '0;
            planned_moves.delete();
            o_drained <= 1'b1;
        end else begin
            if (i_done) begin
                if (planned_moves.size() == 0) begin
                    fails++;
                    $display("%0t ns: result with no request waiting, delta %0d flag %b",
                             $time, i_move_delta, i_both_blocked);
                end else begin
                    want = planned_moves.pop_front();
                    if (i_move_delta !== want.delta) begin
                        fails++;
                        $display("%0t ns: move_delta expected %0d, actual %0d",
                                 $time, want.delta, i_move_delta);
                    end
                    if (i_both_blocked !== want.both_blocked) begin
                        fails++;
                        $display("%0t ns: both_blocked expected %b, actual %b",
                                 $time, want.both_blocked, i_both_blocked);
                    end
                end
            end
            if (i_start && !i_busy) begin
                planned_moves.push_back(predict_move(i_current_angle, i_target_angle,
                                                     zone_lo_q, zone_hi_q));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ZONE_LOW: begin
                        zone_lo_q <= i_cfg_data;
                    end
                    REG_ZONE_HIGH: begin
                        zone_hi_q <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            o_drained <= (planned_moves.size() == 0);
        end
    end

endmodule

>>> tb/tb_forbidden_zone_angular_path_select.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_forbidden_zone_angular_path_select
// Drives directed and random move requests through a series of zone settings
// and sender idling patterns; the checker beside the block judges each result.
// ============================================================================
module tb_forbidden_zone_angular_path_select;
    import fzap_pkg::*;

    localparam int RESET_CYCLES  = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int PHASE_COUNT   = 11;
    localparam int PHASE_ITEMS   = 114;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [ANGLE_W-1:0] i_current_angle;
    logic signed [ANGLE_W-1:0] i_target_angle;
    logic                      i_cfg_we;
    logic [IDX_W-1:0]          i_cfg_idx;
    logic [REG_W-1:0]          i_cfg_data;
    logic                      o_done;
    logic signed [ANGLE_W-1:0] o_move_delta;
    logic                      o_both_blocked;

    int   fail_count;
    logic drained;
    int   idle_pct = 0;
    int   stall_cycles = 0;
    int   zone_lo_set = 0;
    int   zone_hi_set = 0;

    always #4 i_clk = ~i_clk;

    forbidden_zone_angular_path_select u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_current_angle (i_current_angle),
        .i_target_angle  (i_target_angle),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_move_delta    (o_move_delta),
        .o_both_blocked  (o_both_blocked)
    );

    fzap_move_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_current_angle (i_current_angle),
        .i_target_angle  (i_target_angle),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_done          (o_done),
        .i_move_delta    (o_move_delta),
        .i_both_blocked  (o_both_blocked),
        .o_fail_count    (fail_count),
        .o_drained       (drained)
    );

    // Watchdog: ends the run if neither a request nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Brings any angle back into the port's nominal range.
    function automatic int fold(input int a);
        int r;
        r = a;
        while (r > FULL_TURN - 1) r -= FULL_TURN;
        while (r < -FULL_TURN) r += FULL_TURN;
        return r;
    endfunction

    // Presents one request after a random idle gap and returns once it is taken.
    // start is left high so that back-to-back requests need no extra cycle.
    task automatic send_request(input int cur, input int tgt);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start           <= 1'b1;
        i_current_angle <= cur[ANGLE_W-1:0];
        i_target_angle  <= tgt[ANGLE_W-1:0];
        do @(posedge i_clk); while (busy);
    endtask

    // Holds requests back until every outstanding result has come out.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (!drained);
    endtask

    // Both zone edges are written while the block is idle.
    task automatic set_zone(input int lo, input int hi);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ZONE_LOW;
        i_cfg_data <= lo[REG_W-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= REG_ZONE_HIGH;
        i_cfg_data <= hi[REG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        zone_lo_set = lo;
        zone_hi_set = hi;
    endtask

    // One random request, biased towards the arrival margin, the half turn,
    // equal angles and the zone edges.
    task automatic random_request();
        int kind;
        int cur;
        int tgt;
        kind = $urandom_range(9);
        cur  = int'($urandom_range(71999)) - FULL_TURN;
        tgt  = int'($urandom_range(71999)) - FULL_TURN;
        case (kind)
            0, 1: begin
                // Whole 17-bit range, out-of-range angles included.
                cur = $urandom_range(131071);
                tgt = $urandom_range(131071);
            end
            2: begin
                tgt = $urandom_range(1) ? cur : fold(cur + FULL_TURN);
            end
            3: begin
                tgt = fold(cur + int'($urandom_range(71)) * WAYPOINT_STEP + ARRIVE_MARGIN
                           + int'($urandom_range(4)) - 2);
            end
            4: begin
                tgt = fold(cur + int'($urandom_range(1000)) - 500);
            end
            5: begin
                tgt = fold(cur + HALF_TURN + int'($urandom_range(6)) - 3);
            end
            6, 7: begin
                cur = fold(($urandom_range(1) ? zone_lo_set : zone_hi_set)
                           + int'($urandom_range(4)) - 2);
            end
            default: begin
            end
        endcase
        send_request(cur, tgt);
    endtask

    initial begin
        start           <= 1'b0;
        i_rst_n         <= 1'b0;
        i_current_angle <= '0;
        i_target_angle  <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_ZONE_LOW;
        i_cfg_data      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: the reset state first, then a plain zone.
        send_request(0, 0);
        send_request(-65536, 65535);
        send_request(0, 18000);
        send_request(35999, -36000);
        set_zone(9000, 18000);
        send_request(0, 0);
        send_request(-36000, 0);
        send_request(36000, 0);
        send_request(65535, -65536);
        send_request(0, 18000);
        send_request(18000, 0);
        send_request(0, 250);
        send_request(0, 249);
        send_request(0, 251);
        send_request(0, 750);
        send_request(13000, 20000);
        send_request(8999, 18001);
        send_request(9000, 8000);
        send_request(18000, 19000);
        send_request(20000, 5000);
        send_request(5000, 20000);
        send_request(-1, 1);
        send_request(1, -1);
        send_request(-18000, 18000);
        send_request(17999, -18001);

        // Random phases, each with its own zone and sender idling.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       set_zone(0, 0);
                1:       set_zone(9000, 18000);
                2:       set_zone(30000, 6000);
                3:       set_zone(0, 35999);
                4:       set_zone(35999, 0);
                5:       set_zone(100, 100);
                6:       set_zone(65535, 1000);
                7:       set_zone(40000, 65535);
                8, 9:    set_zone($urandom_range(35999), $urandom_range(35999));
                default: set_zone($urandom_range(65535), $urandom_range(65535));
            endcase
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 85;
                default: idle_pct = 13;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(39) == 0) wait_drained();
                random_request();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
